// File: src/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 transcoder.
// Holds the byte codes, code unit constants and the result types; no dependencies.
package u8u16_pkg;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD_MIN   = 8'hC2;
	localparam logic [7:0] LEAD3_BASE = 8'hE0;
	localparam logic [7:0] LEAD4_BASE = 8'hF0;
	localparam logic [7:0] LEAD_LIMIT = 8'hF5;
	localparam logic [7:0] LEAD_ED    = 8'hED;
	localparam logic [7:0] LEAD_F4    = 8'hF4;
	localparam logic [7:0] SECOND_A0  = 8'hA0;
	localparam logic [7:0] SECOND_90  = 8'h90;

	localparam logic [15:0] REPL_UNIT = 16'hFFFD;
	localparam logic [15:0] HI_SURR   = 16'hD800;
	localparam logic [15:0] LO_SURR   = 16'hDC00;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	localparam int MAX_UNITS = 4;

	typedef struct packed {
		logic [15:0] code;
		logic        bad;
		logic        fin;
	} unit_t;

	typedef struct packed {
		logic [2:0]            cnt;
		unit_t [MAX_UNITS-1:0] slot;
	} res_t;

endpackage

// File: src/u8u16_byte_if.sv
// Byte request channel: valid/ready handshake with one UTF-8 byte and an end flag.
// No dependencies.
interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

// File: src/u8u16_unit_if.sv
// Code unit request channel: valid/ready handshake with one UTF-16 unit and flags.
// No dependencies.
interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        malformed;
	logic        final_unit;

	modport source (output valid, output code_unit, output malformed, output final_unit,
		input ready);
	modport sink (input valid, input code_unit, input malformed, input final_unit,
		output ready);
endinterface

// File: src/u8u16_decode.sv
// Sequence decoder: pending-sequence state plus the logic that turns one byte
// into up to four code units. Depends on u8u16_pkg.
module u8u16_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       in_byte,
	input  logic             end_of_text,
	output u8u16_pkg::res_t  res
);
	import u8u16_pkg::*;

	logic [7:0]      lead_q;
	logic [1:0]      held_cnt_q;
	logic [1:0][5:0] held_q;

	logic        pending, ok, advance, complete, hold, fresh;
	logic [1:0]  need;
	logic [5:0]  low6;
	logic [20:0] cp;
	logic [19:0] voff;
	logic [15:0] main0, main1;
	logic        main0_bad;
	logic [1:0]  n_f, n_m, n_e;
	logic [2:0]  total;
	logic [7:0]  lead_d;
	logic [1:0]  held_cnt_d;
	logic        f_lead;

	always_comb begin
		pending = (lead_q != 8'd0);
		low6    = in_byte[5:0];
		if (lead_q < LEAD3_BASE) begin
			need = 2'd1;
		end else if (lead_q < LEAD4_BASE) begin
			need = 2'd2;
		end else begin
			need = 2'd3;
		end

		ok = ((in_byte & CONT_MASK) == CONT_TAG);
		// second-byte range limits that rule out overlong, surrogate and >10FFFF
		if (held_cnt_q == 2'd0) begin
			if (lead_q == LEAD3_BASE && in_byte < SECOND_A0) ok = 1'b0;
			if (lead_q == LEAD_ED && in_byte >= SECOND_A0) ok = 1'b0;
			if (lead_q == LEAD4_BASE && in_byte < SECOND_90) ok = 1'b0;
			if (lead_q == LEAD_F4 && in_byte >= SECOND_90) ok = 1'b0;
		end

		advance  = pending && ok;
		complete = advance && ({1'b0, held_cnt_q} + 3'd1 == {1'b0, need});
		hold     = advance && !complete;
		fresh    = !advance;

		unique case (need)
			2'd1:    cp = {10'd0, lead_q[4:0], low6};
			2'd2:    cp = {5'd0, lead_q[3:0], held_q[0], low6};
			default: cp = {lead_q[2:0], held_q[0], held_q[1], low6};
		endcase
		voff = 20'(cp - SUPP_BASE);

		n_f        = (pending && !ok) ? 2'(held_cnt_q + 2'd1) : 2'd0;
		main0      = cp[15:0];
		main1      = LO_SURR | {6'd0, voff[9:0]};
		main0_bad  = 1'b0;
		n_m        = 2'd0;
		f_lead     = 1'b0;
		lead_d     = 8'd0;
		held_cnt_d = 2'd0;

		if (complete) begin
			if (cp > 21'h00FFFF) begin
				main0 = HI_SURR | {6'd0, voff[19:10]};
				n_m   = 2'd2;
			end else begin
				n_m = 2'd1;
			end
		end else if (hold) begin
			lead_d     = lead_q;
			held_cnt_d = 2'(held_cnt_q + 2'd1);
		end else if (fresh) begin
			if (!in_byte[7]) begin
				main0 = {8'd0, in_byte};
				n_m   = 2'd1;
			end else if (in_byte < LEAD_MIN || in_byte >= LEAD_LIMIT) begin
				main0     = REPL_UNIT;
				main0_bad = 1'b1;
				n_m       = 2'd1;
			end else begin
				f_lead = 1'b1;
				lead_d = in_byte;
			end
		end

		// end of text flushes whatever is still pending
		n_e = 2'd0;
		if (end_of_text && (f_lead || hold)) begin
			n_e        = 2'(held_cnt_d + 2'd1);
			lead_d     = 8'd0;
			held_cnt_d = 2'd0;
		end

		total = 3'(n_f) + 3'(n_m) + 3'(n_e);
	end

	always_comb begin
		res.cnt = total;
		for (int k = 0; k < MAX_UNITS; k++) begin
			if (3'(k) < 3'(n_f)) begin
				res.slot[k].code = REPL_UNIT;
				res.slot[k].bad  = 1'b1;
			end else if (3'(k) < 3'(n_f) + 3'(n_m)) begin
				res.slot[k].code = (3'(k) == 3'(n_f)) ? main0 : main1;
				res.slot[k].bad  = (3'(k) == 3'(n_f)) ? main0_bad : 1'b0;
			end else begin
				res.slot[k].code = REPL_UNIT;
				res.slot[k].bad  = 1'b1;
			end
			res.slot[k].fin = end_of_text && (3'(k) + 3'd1 == total);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q     <= 8'd0;
			held_cnt_q <= 2'd0;
		end else if (step) begin
			lead_q     <= lead_d;
			held_cnt_q <= held_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && hold) begin
			held_q[held_cnt_q[0]] <= low6;
		end
	end

endmodule

// File: src/u8u16_outbuf.sv
// Result buffer: holds the units of one byte and sends them one per request.
// Depends on u8u16_pkg and u8u16_unit_if.
module u8u16_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  u8u16_pkg::res_t res,
	output logic            free,
	u8u16_unit_if.source    units
);
	import u8u16_pkg::*;

	logic [2:0]            cnt_q;
	unit_t [MAX_UNITS-1:0] slot_q;
	logic                  pop;

	assign pop  = (cnt_q != 3'd0) && units.ready;
	assign free = (cnt_q == 3'd0) || (cnt_q == 3'd1 && units.ready);

	assign units.valid      = (cnt_q != 3'd0);
	assign units.code_unit  = slot_q[0].code;
	assign units.malformed  = slot_q[0].bad;
	assign units.final_unit = slot_q[0].fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= res.cnt;
		end else if (pop) begin
			cnt_q <= 3'(cnt_q - 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= res.slot;
		end else if (pop) begin
			for (int i = 0; i < MAX_UNITS - 1; i++) begin
				slot_q[i] <= slot_q[i+1];
			end
		end
	end

endmodule

// File: src/utf8_to_utf16_transcoder.sv
// A byte accepted on the byte port is registered in the input stage, then decoded
// and loaded into the result buffer, which drives its first unit on the port.
// Throughput: one byte per cycle while units are taken; a byte releasing more than
// one unit holds back the next byte while the single unit port drains the buffer.
// Reset (arst_n low, asynchronous) drops any pending sequence and queued units.
// Depends on u8u16_pkg, u8u16_byte_if, u8u16_unit_if, u8u16_decode, u8u16_outbuf.
module utf8_to_utf16_transcoder (
	input  logic         clk,
	input  logic         arst_n,
	u8u16_byte_if.sink   bytes,
	u8u16_unit_if.source units
);
	import u8u16_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       load, free;
	res_t       res;

	assign load        = valid_s1 && free;
	assign bytes.ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.in_byte;
			eot_s1  <= bytes.end_of_text;
		end
	end

	u8u16_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (load),
		.in_byte     (byte_s1),
		.end_of_text (eot_s1),
		.res         (res)
	);

	u8u16_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.res    (res),
		.free   (free),
		.units  (units)
	);

endmodule

// File: src/u8u16_checker.sv
// Port-level checks for the transcoder, attached by bind to the top level.
// Depends on u8u16_pkg.
module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        u_valid,
	input logic        u_ready,
	input logic [15:0] u_code,
	input logic        u_bad,
	input logic        u_fin
);
	import u8u16_pkg::*;

	// a stalled request keeps its unit
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		u_valid && !u_ready |=> u_valid && $stable(u_code) && $stable(u_bad) && $stable(u_fin))
		else $error("stalled unit changed");

	a_repl: assert property (@(posedge clk) disable iff (!arst_n)
		u_valid && u_bad |-> u_code == REPL_UNIT)
		else $error("malformed unit is not U+FFFD");

	// a high surrogate always has its low half behind it
	a_surr: assert property (@(posedge clk) disable iff (!arst_n)
		u_valid && u_code[15:10] == HI_SURR[15:10] |-> !u_fin && !u_bad)
		else $error("high surrogate ends the text");

	// the edge that sees reset low has cleared the buffer by the next one
	a_rst: assert property (@(posedge clk) !arst_n |=> !u_valid)
		else $error("unit offered after reset");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.u_valid (units.valid),
	.u_ready (units.ready),
	.u_code  (units.code_unit),
	.u_bad   (units.malformed),
	.u_fin   (units.final_unit)
);
